// File: rtl/assert_macros.svh
// Assertion macros for the checker file.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// File: rtl/i2cbe_pkg.sv
// Package for the I2C master bit engine: opcodes, status codes, CSR indexes,
// reset values and the structs passed between modules. No dependencies.
package i2cbe_pkg;

   typedef enum logic [2:0] {
      OP_NONE      = 3'd0,
      OP_START     = 3'd1,
      OP_STOP      = 3'd2,
      OP_WRITE     = 3'd3,
      OP_WAIT_ACK  = 3'd4,
      OP_READ      = 3'd5,
      OP_SEND_ACK  = 3'd6,
      OP_SEND_NACK = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_START_FAIL = 2'd1,
      ST_NO_ACK     = 2'd2
   } status_type;

   localparam int CSR_IDX_W = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_HALF_BIT = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACK_POLL = 8'd1;

   localparam logic [15:0] HALF_BIT_RESET = 16'd25;
   localparam logic [7:0]  ACK_POLL_RESET = 8'd80;
   localparam logic [3:0]  BITS_PER_BYTE  = 4'd8;

   typedef struct packed {
      logic [15:0] half_bit_ticks;
      logic [7:0]  ack_poll_limit;
   } cfg_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_level;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_data;
      logic [1:0] status;
   } rsp_type;

endpackage

// File: rtl/i2cbe_if.sv
// Channel interfaces of the I2C master bit engine: request, response and CSR.
// Plain valid/ready channels; no package dependency.
interface i2cbe_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] operation;
   logic [7:0] write_data;
   logic       sda_sample;
   modport source (output valid, operation, write_data, sda_sample, input ready);
   modport sink (input valid, operation, write_data, sda_sample, output ready);
endinterface

interface i2cbe_rsp_if;
   logic       valid;
   logic       ready;
   logic       scl_level;
   logic       sda_level;
   logic       busy_res;
   logic       done_res;
   logic [7:0] read_data;
   logic [1:0] status;
   modport source (output valid, scl_level, sda_level, busy_res, done_res, read_data,
                   status, input ready);
   modport sink (input valid, scl_level, sda_level, busy_res, done_res, read_data,
                 status, output ready);
endinterface

interface i2cbe_csr_if;
   logic        valid;
   logic        ready;
   logic [7:0]  index;
   logic [15:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/i2cbe_csr.sv
// Configuration registers of the I2C master bit engine.
// Depends on i2cbe_pkg.
module i2cbe_csr
   import i2cbe_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_en,
   input  logic [CSR_IDX_W-1:0] wr_index,
   input  logic [15:0]          wr_data,
   output cfg_type              cfg
);

   logic [15:0] half_bit_ff;
   logic [7:0]  ack_poll_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         half_bit_ff <= HALF_BIT_RESET;
         ack_poll_ff <= ACK_POLL_RESET;
      end else if (wr_en) begin
         // unknown indexes are dropped
         if (wr_index == CSR_HALF_BIT) begin
            half_bit_ff <= wr_data;
         end
         if (wr_index == CSR_ACK_POLL) begin
            ack_poll_ff <= wr_data[7:0];
         end
      end
   end

   assign cfg.half_bit_ticks = half_bit_ff;
   assign cfg.ack_poll_limit = ack_poll_ff;

endmodule

// File: rtl/i2cbe_seq.sv
// Bus sequencer of the I2C master bit engine: state registers and the
// one-tick next-state logic. Depends on i2cbe_pkg.
module i2cbe_seq
   import i2cbe_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       tick,
   input  logic [2:0] operation,
   input  logic [7:0] write_data,
   input  logic       sda_sample,
   input  cfg_type    cfg,
   output rsp_type    result
);

   op_type      op_ff, op_in;
   logic [3:0]  phase_ff, phase_in;
   logic [15:0] delay_ff, delay_in;
   logic [3:0]  bit_ff, bit_in;
   logic [7:0]  shift_ff, shift_in;
   logic [7:0]  poll_ff, poll_in;
   logic        scl_ff, scl_in;
   logic        sda_ff, sda_in;
   status_type  status_ff, status_in;
   logic [7:0]  rx_ff, rx_in;
   logic        done;

   // next state for one tick
   always_comb begin
      op_type     run_op;
      logic [3:0] run_phase;
      logic       run;
      logic [3:0] bit_inc;
      logic [7:0] poll_dec;

      op_in     = op_ff;
      phase_in  = phase_ff;
      delay_in  = delay_ff;
      bit_in    = bit_ff;
      shift_in  = shift_ff;
      poll_in   = poll_ff;
      scl_in    = scl_ff;
      sda_in    = sda_ff;
      status_in = status_ff;
      rx_in     = rx_ff;
      done      = 1'b0;
      run       = 1'b0;
      run_op    = op_ff;
      run_phase = phase_ff;

      if (op_ff == OP_NONE) begin
         if (op_type'(operation) != OP_NONE) begin
            run       = 1'b1;
            run_op    = op_type'(operation);
            run_phase = 4'd0;
            op_in     = op_type'(operation);
            if (op_type'(operation) == OP_WRITE) begin
               shift_in = write_data;
            end
         end
      end else if (delay_ff != 16'd0) begin
         delay_in = delay_ff - 16'd1;
      end else begin
         run = 1'b1;
      end

      bit_inc  = bit_ff + 4'd1;
      poll_dec = poll_ff - 8'd1;

      if (run) begin
         // default action of a step: wait, then advance
         delay_in = cfg.half_bit_ticks;
         phase_in = run_phase + 4'd1;
         case (run_op)
            OP_START: begin
               if (run_phase == 4'd0) begin
                  scl_in = 1'b1;
                  sda_in = 1'b1;
               end else if (run_phase == 4'd1) begin
                  if (!sda_sample) begin
                     done      = 1'b1;
                     status_in = ST_START_FAIL;
                  end else begin
                     sda_in = 1'b0;
                  end
               end else begin
                  done = 1'b1;
                  if (sda_sample) begin
                     status_in = ST_START_FAIL;
                  end else begin
                     scl_in    = 1'b0;
                     status_in = ST_OK;
                  end
               end
            end
            OP_STOP: begin
               if (run_phase == 4'd0) begin
                  scl_in = 1'b0;
                  sda_in = 1'b0;
               end else if (run_phase == 4'd1) begin
                  scl_in = 1'b1;
               end else begin
                  sda_in    = 1'b1;
                  done      = 1'b1;
                  status_in = ST_OK;
               end
            end
            OP_WRITE: begin
               if (run_phase == 4'd0) begin
                  scl_in = 1'b0;
                  bit_in = 4'd0;
               end else if (run_phase == 4'd1) begin
                  sda_in   = shift_ff[7];
                  shift_in = {shift_ff[6:0], 1'b0};
               end else if (run_phase == 4'd2) begin
                  scl_in = 1'b1;
               end else if (run_phase == 4'd3) begin
                  scl_in   = 1'b0;
                  bit_in   = bit_inc;
                  phase_in = (bit_inc >= BITS_PER_BYTE) ? 4'd4 : 4'd1;
               end else begin
                  done      = 1'b1;
                  status_in = ST_OK;
               end
            end
            OP_WAIT_ACK: begin
               if (run_phase == 4'd0) begin
                  scl_in = 1'b0;
               end else if (run_phase == 4'd1) begin
                  sda_in = 1'b1;
               end else if (run_phase == 4'd2) begin
                  scl_in  = 1'b1;
                  poll_in = cfg.ack_poll_limit;
               end else if (run_phase == 4'd3) begin
                  if (!sda_sample) begin
                     scl_in    = 1'b0;
                     done      = 1'b1;
                     status_in = ST_OK;
                  end else begin
                     poll_in = poll_dec;
                     if (poll_dec == 8'd0) begin
                        // timeout: fall into a stop sequence
                        scl_in = 1'b0;
                        sda_in = 1'b0;
                     end else begin
                        // keep polling, no wait
                        delay_in = delay_ff;
                        phase_in = run_phase;
                     end
                  end
               end else if (run_phase == 4'd4) begin
                  scl_in = 1'b1;
               end else begin
                  sda_in    = 1'b1;
                  done      = 1'b1;
                  status_in = ST_NO_ACK;
               end
            end
            OP_READ: begin
               if (run_phase == 4'd0) begin
                  sda_in   = 1'b1;
                  shift_in = 8'd0;
                  bit_in   = 4'd0;
               end else if (run_phase == 4'd1) begin
                  shift_in = {shift_ff[6:0], 1'b0};
                  scl_in   = 1'b0;
               end else if (run_phase == 4'd2) begin
                  scl_in = 1'b1;
               end else if (run_phase == 4'd3) begin
                  bit_in = bit_inc;
                  scl_in = 1'b0;
                  if (bit_inc >= BITS_PER_BYTE) begin
                     shift_in = {shift_ff[7:1], shift_ff[0] | sda_sample};
                     phase_in = 4'd4;
                  end else begin
                     shift_in = {shift_ff[6:1], shift_ff[0] | sda_sample, 1'b0};
                     phase_in = 4'd2;
                  end
               end else begin
                  rx_in     = shift_ff;
                  done      = 1'b1;
                  status_in = ST_OK;
               end
            end
            OP_SEND_ACK: begin
               if (run_phase == 4'd0) begin
                  sda_in = 1'b0;
               end else if (run_phase == 4'd1) begin
                  scl_in = 1'b1;
               end else if (run_phase == 4'd2) begin
                  scl_in = 1'b0;
               end else begin
                  sda_in    = 1'b1;
                  done      = 1'b1;
                  status_in = ST_OK;
               end
            end
            OP_SEND_NACK: begin
               if (run_phase == 4'd0) begin
                  scl_in = 1'b0;
                  sda_in = 1'b1;
               end else if (run_phase == 4'd1) begin
                  scl_in = 1'b1;
               end else begin
                  scl_in    = 1'b0;
                  done      = 1'b1;
                  status_in = ST_OK;
               end
            end
            default: begin
               delay_in = delay_ff;
               phase_in = phase_ff;
            end
         endcase
         if (done) begin
            op_in    = OP_NONE;
            phase_in = 4'd0;
            delay_in = 16'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff     <= OP_NONE;
         phase_ff  <= 4'd0;
         delay_ff  <= 16'd0;
         bit_ff    <= 4'd0;
         shift_ff  <= 8'd0;
         poll_ff   <= 8'd0;
         scl_ff    <= 1'b1;
         sda_ff    <= 1'b1;
         status_ff <= ST_OK;
         rx_ff     <= 8'd0;
      end else if (tick) begin
         op_ff     <= op_in;
         phase_ff  <= phase_in;
         delay_ff  <= delay_in;
         bit_ff    <= bit_in;
         shift_ff  <= shift_in;
         poll_ff   <= poll_in;
         scl_ff    <= scl_in;
         sda_ff    <= sda_in;
         status_ff <= status_in;
         rx_ff     <= rx_in;
      end
   end

   assign result.scl_level = scl_in;
   assign result.sda_level = sda_in;
   assign result.busy_res  = (op_in != OP_NONE);
   assign result.done_res  = done;
   assign result.read_data = rx_in;
   assign result.status    = status_in;

endmodule

// File: rtl/i2cbe_out_reg.sv
// Response register of the I2C master bit engine: holds one result beat and
// frees itself the cycle it is taken. Depends on i2cbe_pkg.
module i2cbe_out_reg
   import i2cbe_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    load,
   input  rsp_type load_data,
   input  logic    out_ready,
   output logic    out_valid,
   output rsp_type out_data,
   output logic    can_load
);

   logic    valid_ff;
   rsp_type data_ff;

   assign can_load = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (out_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// File: rtl/i2c_master_bit_engine_core.sv
// I2C master bit engine, top level. Each request beat is one timing tick and
// yields exactly one response beat with the driven SCL/SDA levels, busy, done,
// last read byte and last status. Ticks are accepted one per clock: the
// sequencer state advances on each accepted beat, and the response sits in
// one output register, so req_ch.ready stays high unless a response is
// stalled downstream. The response appears in the cycle after its request
// beat is accepted. The CSR channel is always ready; index 0 is half_bit_ticks,
// index 1 is ack_poll_limit, others are dropped. Depends on i2cbe_pkg,
// i2cbe_if, i2cbe_csr, i2cbe_seq and i2cbe_out_reg.
module i2c_master_bit_engine_core
   import i2cbe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   i2cbe_req_if.sink   req_ch,
   i2cbe_rsp_if.source rsp_ch,
   i2cbe_csr_if.sink   csr_ch
);

   cfg_type cfg;
   rsp_type seq_result;
   rsp_type rsp_data;
   logic    can_load;
   logic    tick;

   // CSR writes never stall
   assign csr_ch.ready = 1'b1;

   i2cbe_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_ch.valid),
      .wr_index (csr_ch.index),
      .wr_data  (csr_ch.data),
      .cfg      (cfg)
   );

   // one tick per accepted request beat
   assign req_ch.ready = can_load;
   assign tick         = req_ch.valid && can_load;

   i2cbe_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .tick       (tick),
      .operation  (req_ch.operation),
      .write_data (req_ch.write_data),
      .sda_sample (req_ch.sda_sample),
      .cfg        (cfg),
      .result     (seq_result)
   );

   // response register: parts the two handshakes
   i2cbe_out_reg u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (tick),
      .load_data (seq_result),
      .out_ready (rsp_ch.ready),
      .out_valid (rsp_ch.valid),
      .out_data  (rsp_data),
      .can_load  (can_load)
   );

   assign rsp_ch.scl_level = rsp_data.scl_level;
   assign rsp_ch.sda_level = rsp_data.sda_level;
   assign rsp_ch.busy_res  = rsp_data.busy_res;
   assign rsp_ch.done_res  = rsp_data.done_res;
   assign rsp_ch.read_data = rsp_data.read_data;
   assign rsp_ch.status    = rsp_data.status;

endmodule

// File: rtl/i2cbe_checker.sv
// Port-level checker for the I2C master bit engine, bound to the top level.
// Depends on assert_macros.svh and i2cbe_pkg.
`include "assert_macros.svh"

module i2cbe_checker
   import i2cbe_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_busy,
   input logic       rsp_done,
   input logic       rsp_scl,
   input logic       rsp_sda,
   input logic [7:0] rsp_read_data,
   input logic [1:0] rsp_status
);

   logic [13:0] rsp_bits;

   assign rsp_bits = {rsp_scl, rsp_sda, rsp_busy, rsp_done, rsp_read_data, rsp_status};

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_bits))
   `ASSERT_IMPLY(a_done_idle, clock, reset, rsp_valid && rsp_done, !rsp_busy)
   `ASSERT_IMPLY(a_status_code, clock, reset, rsp_valid, rsp_status != 2'd3)

endmodule

bind i2c_master_bit_engine_core i2cbe_checker u_i2cbe_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_busy      (rsp_ch.busy_res),
   .rsp_done      (rsp_ch.done_res),
   .rsp_scl       (rsp_ch.scl_level),
   .rsp_sda       (rsp_ch.sda_level),
   .rsp_read_data (rsp_ch.read_data),
   .rsp_status    (rsp_ch.status)
);
